/* rtl/core/fircb_pkg.sv */
// ----------------------------------------------------------------------------
// fircb_pkg
// Shared types and constants of the circular-buffer FIR filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package fircb_pkg;

   // operation codes carried in req_tuser
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_COEFF  = 1'b1;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int COEFF_W   = 16;
   localparam int CIDX_W    = 7;
   localparam int FRAC_W    = 4;
   localparam int PROD_W    = 32;
   localparam int REQ_TDATA_W = 40;   // 39 bits of fields, padded to bytes
   localparam int RSP_TDATA_W = 16;

   // number of coefficient indices reachable through the 7-bit field
   localparam int CIDX_SPAN = 128;

   // reset value of the fraction-bits register
   localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd15;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEFF_W-1:0]  coeff_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   // unpacked request beat
   typedef struct packed {
      logic [COEFF_W-1:0]  coeff_value;
      logic [CIDX_W-1:0]   coeff_index;
      logic [SAMPLE_W-1:0] sample;
   } req_fields_type;

endpackage : fircb_pkg

`default_nettype wire

/* rtl/core/fircb_ram.sv */
// ----------------------------------------------------------------------------
// fircb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fircb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : fircb_ram

`default_nettype wire

/* rtl/core/fir_filter_circular_buffer_core.sv */
// ----------------------------------------------------------------------------
// fir_filter_circular_buffer_core
// Mono direct-form FIR filter over a circular delay line, one MAC per tap.
// ----------------------------------------------------------------------------
// A sample beat (req_tuser = 0) stores its sample at the write position and
// then runs one multiply-accumulate per tap over min(TAPS,128) taps, newest
// sample first; the delay line and coefficient store are two RAMs that are
// read once per cycle. No new beat is accepted until the result of a sample
// is loaded for rsp. A coefficient beat (req_tuser = 1) returns nothing; an
// index at or beyond TAPS is ignored. The sum is shifted right by
// coeff_frac_bits toward zero and saturated to 16 bits, rsp_tuser flagging a
// clip. A new beat is accepted while a finished result waits on rsp. After
// reset a clearing pass zeroes both stores; csr writes are taken during it
// but no beat is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_circular_buffer_core
   import fircb_pkg::*;
#(
   parameter int TAPS = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: tdata = {pad, coeff_value, coeff_index, sample}, low bit first:
   //   [15:0] sample, [22:16] coeff_index, [38:23] coeff_value, [39] pad
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: [0] operation
   input  wire logic [0:0]             req_tuser,
   // response: tdata [15:0] filtered
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // tuser: [0] saturated
   output logic [0:0]                  rsp_tuser,
   // configuration: coeff_frac_bits
   input  wire logic                   csr_we,
   input  wire logic [FRAC_W-1:0]      csr_wdata
);

   localparam int AW    = $clog2(TAPS);
   localparam int CDEPTH = (TAPS < CIDX_SPAN) ? TAPS : CIDX_SPAN;
   localparam int CAW   = $clog2(CDEPTH);
   localparam int ACC_W = PROD_W + CAW;

   localparam logic [ACC_W-1:0] POS_MAX = ACC_W'(32767);
   localparam logic [ACC_W-1:0] NEG_MAX = ACC_W'(32768);

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_ABS   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]     wr_pos_ff, wr_pos_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CAW-1:0]    tap_cnt_ff, tap_cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              prod_vld_ff;
   prod_type          prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0]  mag_ff;
   logic              neg_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic              rsp_vld_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic              rsp_sat_ff;

   req_fields_type    req;
   logic              accept, acc_sample, acc_coeff, cidx_ok, rsp_load;

   logic              dl_we, co_we;
   logic [AW-1:0]     dl_waddr;
   logic [SAMPLE_W-1:0] dl_wdata, dl_q;
   logic [CAW-1:0]    co_waddr;
   logic [COEFF_W-1:0] co_wdata, co_q;
   logic              rd_en;

   logic [ACC_W-1:0]  shifted;
   logic              sat;
   logic [SAMPLE_W-1:0] res_mag, res_val;

   assign req        = req_fields_type'(req_tdata[REQ_TDATA_W-2:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign acc_sample = accept && (req_tuser[0] == OP_FILTER);
   assign acc_coeff  = accept && (req_tuser[0] == OP_COEFF);
   assign cidx_ok    = (32'(req.coeff_index) < 32'(TAPS));
   assign rd_en      = (state_ff == S_MAC);

   // RAM write port selection: clearing pass or beat
   always_comb begin
      dl_we    = 1'b0;
      dl_waddr = wr_pos_ff;
      dl_wdata = req.sample;
      co_we    = 1'b0;
      co_waddr = req.coeff_index[CAW-1:0];
      co_wdata = req.coeff_value;
      if (state_ff == S_CLEAR) begin
         dl_we    = 1'b1;
         dl_waddr = clr_cnt_ff;
         dl_wdata = '0;
         co_we    = ({1'b0, clr_cnt_ff} < (AW+1)'(CDEPTH));
         co_waddr = clr_cnt_ff[CAW-1:0];
         co_wdata = '0;
      end else begin
         dl_we = acc_sample;
         co_we = acc_coeff && cidx_ok;
      end
   end

   fircb_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_delay_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (dl_q)
   );

   fircb_ram #(.WIDTH(COEFF_W), .DEPTH(CDEPTH)) u_coeff_ram (
      .clock   (clock),
      .wr_en   (co_we),
      .wr_addr (co_waddr),
      .wr_data (co_wdata),
      .rd_en   (rd_en),
      .rd_addr (tap_cnt_ff),
      .rd_data (co_q)
   );

   // shift toward zero and saturate
   always_comb begin
      shifted = mag_ff >> frac_ff;
      sat     = neg_ff ? (shifted > NEG_MAX) : (shifted > POS_MAX);
      res_mag = shifted[SAMPLE_W-1:0];
      if (sat) begin
         res_val = neg_ff ? 16'h8000 : 16'h7fff;
      end else begin
         res_val = neg_ff ? (16'd0 - res_mag) : res_mag;
      end
   end

   assign rsp_load = (state_ff == S_OUT) && (!rsp_vld_ff || rsp_tready);

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      wr_pos_in  = wr_pos_ff;
      rd_ptr_in  = rd_ptr_ff;
      tap_cnt_in = tap_cnt_ff;
      rd_vld_in  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(TAPS-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (acc_sample) begin
               rd_ptr_in  = wr_pos_ff;
               tap_cnt_in = '0;
               wr_pos_in  = (wr_pos_ff == AW'(TAPS-1)) ? '0 : wr_pos_ff + AW'(1);
               state_in   = S_MAC;
            end
         end
         S_MAC: begin
            rd_vld_in  = 1'b1;
            rd_ptr_in  = (rd_ptr_ff == '0) ? AW'(TAPS-1) : rd_ptr_ff - AW'(1);
            tap_cnt_in = tap_cnt_ff + CAW'(1);
            if (tap_cnt_ff == CAW'(CDEPTH-1)) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_cnt_ff  <= '0;
         wr_pos_ff   <= '0;
         rd_ptr_ff   <= '0;
         tap_cnt_ff  <= '0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         frac_ff     <= FRAC_RESET;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         wr_pos_ff   <= wr_pos_in;
         rd_ptr_ff   <= rd_ptr_in;
         tap_cnt_ff  <= tap_cnt_in;
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= rd_vld_ff;
         if (csr_we) begin
            frac_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // MAC datapath: multiply, accumulate, magnitude
   always_ff @(posedge clock) begin
      prod_ff <= prod_type'(sample_type'(dl_q)) * prod_type'(coeff_type'(co_q));
      if (acc_sample) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
      if (state_ff == S_ABS) begin
         neg_ff <= acc_ff[ACC_W-1];
         mag_ff <= acc_ff[ACC_W-1] ? (ACC_W'(0) - acc_ff) : acc_ff;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_val;
         rsp_sat_ff  <= sat;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

endmodule : fir_filter_circular_buffer_core

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the circular-buffer FIR filter core. A directed table
// covers sample and coefficient extremes, truncation toward zero and clipping.
// Random beats then run under several fraction-bit settings. Every result beat
// is scored in order against a behavioral model of the filter held here or a
// hand-typed table result, with random idling on both streams.
// ----------------------------------------------------------------------------

module tb_top;
   import fircb_pkg::*;

   localparam int TAPS = 128;

   // one expected result beat
   typedef struct packed {
      logic [RSP_TDATA_W-1:0] filtered;
      logic                   saturated;
   } fir_out_type;

   // one row of the directed table; chk marks a hand-typed result
   typedef struct packed {
      logic                   op;
      logic [SAMPLE_W-1:0]    smp;
      logic [CIDX_W-1:0]      idx;
      logic [COEFF_W-1:0]     val;
      bit                     chk;
      logic [RSP_TDATA_W-1:0] exp_out;
      logic                   exp_sat;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = OP_FILTER;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [FRAC_W-1:0]      csr_wdata = '0;

   // filter model state
   sample_type        fir_line [TAPS];
   coeff_type         fir_coeff [TAPS];
   int                wr_ptr = 0;
   logic [FRAC_W-1:0] frac_bits = FRAC_RESET;

   fir_out_type pending_outputs [$];
   dir_row_type dir_rows [$];

   bit calm = 1'b0;
   int mismatches = 0;
   int samples_sent = 0;
   int coeffs_sent = 0;
   int results_seen = 0;
   int clips_seen = 0;
   int settings_used = 1;

   always #10 clock = ~clock;

   fir_filter_circular_buffer_core #(.TAPS(TAPS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // store a sample, advance the ring, and form the shifted, clipped sum
   function automatic fir_out_type filter_sample(sample_type s);
      longint      acc;
      longint      mag;
      int          newest;
      int          slot;
      fir_out_type r;
      acc = 0;
      newest = wr_ptr;
      fir_line[newest] = s;
      wr_ptr = (newest == TAPS - 1) ? 0 : newest + 1;
      for (int i = 0; i < TAPS; i++) begin
         slot = (newest + TAPS - i) % TAPS;
         acc += longint'(fir_line[slot]) * longint'(fir_coeff[i]);
      end
      // shift the magnitude so the result truncates toward zero
      mag = (acc < 0) ? -acc : acc;
      mag = mag >> frac_bits;
      if (acc < 0)
         mag = -mag;
      if (mag > 32767) begin
         r.filtered = 16'h7FFF;
         r.saturated = 1'b1;
      end else if (mag < -32768) begin
         r.filtered = 16'h8000;
         r.saturated = 1'b1;
      end else begin
         r.filtered = mag[15:0];
         r.saturated = 1'b0;
      end
      return r;
   endfunction

   function automatic dir_row_type stim_row(logic op, logic [15:0] smp, logic [6:0] idx,
                                            logic [15:0] val, bit chk,
                                            logic [15:0] exp_out, logic exp_sat);
      dir_row_type r;
      r.op = op;
      r.smp = smp;
      r.idx = idx;
      r.val = val;
      r.chk = chk;
      r.exp_out = exp_out;
      r.exp_sat = exp_sat;
      return r;
   endfunction

   // drive one request beat, wait for the handshake, update the model
   task automatic send_beat(logic op, logic [15:0] smp, logic [6:0] idx, logic [15:0] val,
                            bit chk, logic [15:0] exp_out, logic exp_sat);
      fir_out_type predicted;
      int          gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, val, idx, smp};
      do @(posedge clock); while (!req_tready);
      if (op == OP_COEFF) begin
         if (idx < TAPS)
            fir_coeff[idx] = val;
         coeffs_sent++;
      end else begin
         predicted = filter_sample(smp);
         if (chk) begin
            predicted.filtered = exp_out;
            predicted.saturated = exp_sat;
         end
         pending_outputs.push_back(predicted);
         samples_sent++;
      end
      // random source idling: mostly short, now and then across a whole sample
      if (!calm && $urandom_range(99) < 38) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(180, 20) : $urandom_range(4, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain all results, then allow a trailing coefficient beat to finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
      repeat (TAPS + 8) @(posedge clock);
   endtask

   task automatic write_frac(logic [FRAC_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      frac_bits = v;
      settings_used++;
   endtask

   // result sink: random backpressure and in-order scoring
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 38);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outputs.size() == 0) begin
               $display("%0t: unexpected result beat filtered %h saturated %b",
                        $time, rsp_tdata, rsp_tuser[0]);
               mismatches++;
            end else begin
               if (rsp_tdata !== pending_outputs[0].filtered) begin
                  $display("%0t: filtered mismatch, expected %h actual %h",
                           $time, pending_outputs[0].filtered, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser[0] !== pending_outputs[0].saturated) begin
                  $display("%0t: saturated mismatch, expected %b actual %b",
                           $time, pending_outputs[0].saturated, rsp_tuser[0]);
                  mismatches++;
               end
               if (pending_outputs[0].saturated)
                  clips_seen++;
               void'(pending_outputs.pop_front());
               results_seen++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [FRAC_W-1:0] phase_frac [5];
      logic              op;
      logic [15:0]       smp;
      logic [6:0]        idx;
      logic [15:0]       val;
      logic [31:0]       rnd;

      foreach (fir_line[i]) begin
         fir_line[i] = '0;
         fir_coeff[i] = '0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset shift of 15; only tap 0 is live at first
      dir_rows.push_back(stim_row(OP_FILTER, 16'h7FFF, 7'h7F, 16'hFFFF, 1, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h8000, 7'h00, 16'h0000, 1, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_COEFF,  16'hFFFF, 7'h00, 16'h7FFF, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h8000, 7'h00, 16'h0000, 1, 16'h8001, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h7FFF, 7'h00, 16'h0000, 1, 16'h7FFE, 0));
      dir_rows.push_back(stim_row(OP_COEFF,  16'h0000, 7'h00, 16'h8000, 0, 16'h0000, 0));
      // most negative squared clips high
      dir_rows.push_back(stim_row(OP_FILTER, 16'h8000, 7'h00, 16'h0000, 1, 16'h7FFF, 1));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h7FFF, 7'h00, 16'h0000, 1, 16'h8001, 0));
      dir_rows.push_back(stim_row(OP_COEFF,  16'h0000, 7'h00, 16'h0001, 0, 16'h0000, 0));
      // tiny negative sum truncates toward zero, not down to -1
      dir_rows.push_back(stim_row(OP_FILTER, 16'hFFFF, 7'h00, 16'h0000, 1, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h0001, 7'h00, 16'h0000, 1, 16'h0000, 0));
      // top tap, then junk in the unused sample field
      dir_rows.push_back(stim_row(OP_COEFF,  16'h0000, 7'h7F, 16'h8000, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_COEFF,  16'hA5A5, 7'h01, 16'h7FFF, 0, 16'h0000, 0));
      // junk in the unused coefficient fields
      dir_rows.push_back(stim_row(OP_FILTER, 16'h4000, 7'h55, 16'hAAAA, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'hC000, 7'h2A, 16'h5555, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_COEFF,  16'h0000, 7'h40, 16'h5555, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_COEFF,  16'h0000, 7'h2A, 16'hFFFF, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h7FFF, 7'h00, 16'h0000, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h8000, 7'h00, 16'h0000, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h0000, 7'h00, 16'h0000, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'h1234, 7'h00, 16'h0000, 0, 16'h0000, 0));
      dir_rows.push_back(stim_row(OP_FILTER, 16'hEDCB, 7'h00, 16'h0000, 0, 16'h0000, 0));

      foreach (dir_rows[r])
         send_beat(dir_rows[r].op, dir_rows[r].smp, dir_rows[r].idx, dir_rows[r].val,
                   dir_rows[r].chk, dir_rows[r].exp_out, dir_rows[r].exp_sat);

      // random phases, shift extremes first; the second phase never idles
      phase_frac[0] = 4'd0;
      phase_frac[1] = 4'd15;
      phase_frac[2] = 4'd1;
      phase_frac[3] = 4'd14;
      phase_frac[4] = 4'($urandom_range(13, 2));
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         write_frac(phase_frac[p]);
         calm = (p == 1);
         for (int k = 0; k < 96; k++) begin
            idx = 7'($urandom_range(127));
            smp = 16'($urandom);
            val = 16'($urandom);
            rnd = $urandom;
            case ($urandom_range(9))
               0, 1: smp = {{7{rnd[8]}}, rnd[8:0]};
               2:    smp = rnd[9] ? 16'h7FFF : 16'h8000;
               default: ;
            endcase
            case ($urandom_range(9))
               0, 1, 2, 3: val = {{7{rnd[18]}}, rnd[18:10]};
               4, 5:       val = 16'h0000;
               6:          val = rnd[19] ? 16'h7FFF : 16'h8000;
               default: ;
            endcase
            op = ($urandom_range(3) == 0) ? OP_COEFF : OP_FILTER;
            send_beat(op, smp, idx, val, 1'b0, 16'h0000, 1'b0);
         end
      end
      calm = 1'b0;
      wait_idle();

      $display("covered %0d sample beats and %0d coefficient loads over %0d shift settings",
               samples_sent, coeffs_sent, settings_used);
      $display("scored %0d result beats, %0d of them clipped, %0d mismatches",
               results_seen, clips_seen, mismatches);
      if (mismatches == 0 && pending_outputs.size() == 0)
         $display("fir_filter_circular_buffer_core regression: pass");
      else
         $display("fir_filter_circular_buffer_core regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", pending_outputs.size());
      $display("fir_filter_circular_buffer_core regression: fail");
      $finish;
   end

endmodule

/* fir_filter_circular_buffer_core.f */
rtl/core/fircb_pkg.sv
rtl/core/fircb_ram.sv
rtl/core/fir_filter_circular_buffer_core.sv
bench/tb_top.sv
